FILE: rtl/core/subnet_interface_match_top_assert.svh
// Assertion macros shared by the subnet interface match RTL.
// Depends on nothing; every macro samples on clock and is disabled during reset.
`ifndef SUBNET_INTERFACE_MATCH_TOP_ASSERT_SVH
`define SUBNET_INTERFACE_MATCH_TOP_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SIFM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define SIFM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/sifm_pkg.sv
// Shared types and constants for the subnet interface match block.
// Used by sifm_seq, sifm_eval and the top level; depends on nothing.
`timescale 1ns / 1ps

package sifm_pkg;

   localparam int NUM_ENTRIES = 32;
   localparam int NUM_IFACES  = 16;
   localparam int ENTRY_AW    = $clog2(NUM_ENTRIES);

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CHECK  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_WAIT
   } seq_state_type;

   typedef struct packed {
      op_type      op;
      logic [4:0]  slot;
      logic        slot_enable;
      logic [3:0]  iface_id;
      logic [31:0] mask_in;
      logic [31:0] subnet_in;
      logic [31:0] ip_addr;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [3:0] best_iface;
      logic       addr_valid;
   } rsp_type;

   // One table entry as stored in the entry RAM.
   typedef struct packed {
      logic [3:0]  iface;
      logic [31:0] mask;
      logic [31:0] subnet;
   } entry_type;

   // Valid-bit update for one slot.
   typedef struct packed {
      logic                en;
      logic [ENTRY_AW-1:0] idx;
      logic                value;
   } used_wr_type;

   // Scan control from the sequencer to the evaluator.
   typedef struct packed {
      logic                clear;
      logic                data_vld;
      logic [ENTRY_AW-1:0] data_idx;
      logic                data_last;
   } seq_ctl_type;

endpackage

FILE: rtl/core/sifm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module sifm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sifm_seq.sv
// Scan sequencer: walks the entry RAM one address per cycle and tracks read latency.
// Depends on sifm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "subnet_interface_match_top_assert.svh"

module sifm_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start_scan,
   output logic                          busy,
   output logic [sifm_pkg::ENTRY_AW-1:0] rd_addr,
   output sifm_pkg::seq_ctl_type         ctl
);

   localparam logic [sifm_pkg::ENTRY_AW-1:0] LAST_IDX =
      sifm_pkg::ENTRY_AW'(sifm_pkg::NUM_ENTRIES - 1);

   sifm_pkg::seq_state_type state_ff, state_in;
   logic [sifm_pkg::ENTRY_AW-1:0] cnt_ff, cnt_in;
   logic                          vld_ff, vld_in;
   logic [sifm_pkg::ENTRY_AW-1:0] idx_ff;
   logic                          rd_en;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sifm_pkg::SEQ_IDLE: begin
            if (start_scan) state_in = sifm_pkg::SEQ_SCAN;
         end
         sifm_pkg::SEQ_SCAN: begin
            if (cnt_ff == LAST_IDX) state_in = sifm_pkg::SEQ_WAIT;
         end
         sifm_pkg::SEQ_WAIT: begin
            state_in = sifm_pkg::SEQ_IDLE;
         end
         default: begin
            state_in = sifm_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      busy  = 1'b0;
      rd_en = 1'b0;
      unique case (state_ff)
         sifm_pkg::SEQ_IDLE: begin
            busy = 1'b0;
         end
         sifm_pkg::SEQ_SCAN: begin
            busy  = 1'b1;
            rd_en = 1'b1;
         end
         sifm_pkg::SEQ_WAIT: begin
            busy = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (start_scan) begin
         cnt_in = '0;
      end else if (rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end
      vld_in = rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sifm_pkg::SEQ_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
      idx_ff <= cnt_ff;
   end

   assign rd_addr       = cnt_ff;
   assign ctl.clear     = start_scan;
   assign ctl.data_vld  = vld_ff;
   assign ctl.data_idx  = idx_ff;
   assign ctl.data_last = vld_ff && (idx_ff == LAST_IDX);

   `SIFM_ASSERT_NEXT(a_scan_starts_at_zero, start_scan, (state_ff == sifm_pkg::SEQ_SCAN) && (cnt_ff == '0), "scan did not start at entry zero")
   `SIFM_ASSERT_NEXT(a_last_ends_scan, ctl.data_last, state_ff == sifm_pkg::SEQ_IDLE, "sequencer not idle after last entry")
   `SIFM_ASSERT_NOW(a_data_while_busy, ctl.data_vld, busy, "entry data arrived while idle")

endmodule

FILE: rtl/core/sifm_eval.sv
// Match evaluator: valid bits, per-entry match test, best-entry tracking, result register.
// Depends on sifm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "subnet_interface_match_top_assert.svh"

module sifm_eval (
   input  logic                  clock,
   input  logic                  reset,
   input  sifm_pkg::used_wr_type used_wr,
   input  sifm_pkg::seq_ctl_type ctl,
   input  sifm_pkg::entry_type   entry,
   input  sifm_pkg::op_type      scan_op,
   input  logic [31:0]           ip_addr,
   input  logic [3:0]            iface_id,
   input  logic                  imm_rsp,
   output logic                  rsp_strobe,
   output sifm_pkg::rsp_type     rsp_data
);

   logic [sifm_pkg::NUM_ENTRIES-1:0] used_ff;
   logic [31:0]       best_mask_ff, best_mask_in;
   logic [3:0]        best_iface_ff, best_iface_in;
   logic              found_ff, found_in;
   logic              chk_ff, chk_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sifm_pkg::rsp_type rsp_ff, rsp_in;
   logic              hit;
   logic              iface_ok;

   assign hit      = used_ff[ctl.data_idx] && ((ip_addr & entry.mask) == entry.subnet);
   assign iface_ok = 32'(iface_id) < 32'(sifm_pkg::NUM_IFACES);

   always_comb begin
      best_mask_in  = best_mask_ff;
      best_iface_in = best_iface_ff;
      found_in      = found_ff;
      chk_in        = chk_ff;
      if (ctl.clear) begin
         best_mask_in  = '0;
         best_iface_in = '0;
         found_in      = 1'b0;
         chk_in        = 1'b0;
      end else if (ctl.data_vld) begin
         // strictly greater keeps the lowest slot on ties and skips zero masks
         if (hit && (entry.mask > best_mask_ff)) begin
            best_mask_in  = entry.mask;
            best_iface_in = entry.iface;
            found_in      = 1'b1;
         end
         if (hit && (entry.iface == iface_id)) begin
            chk_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = ctl.data_last || imm_rsp;
      rsp_in       = '0;
      if (ctl.data_last) begin
         case (scan_op)
            sifm_pkg::OP_LOOKUP: begin
               rsp_in.found      = found_in;
               rsp_in.best_iface = best_iface_in;
            end
            sifm_pkg::OP_CHECK: begin
               rsp_in.addr_valid = iface_ok && chk_in;
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (used_wr.en) begin
            used_ff[used_wr.idx] <= used_wr.value;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      best_mask_ff  <= best_mask_in;
      best_iface_ff <= best_iface_in;
      found_ff      <= found_in;
      chk_ff        <= chk_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `SIFM_ASSERT_NOW(a_no_iface_without_found, rsp_valid_ff && !rsp_ff.found, rsp_ff.best_iface == '0, "interface reported without a match")
   `SIFM_ASSERT_NOW(a_one_result_kind, rsp_valid_ff, !(rsp_ff.found && rsp_ff.addr_valid), "lookup and check fields both set")
   `SIFM_ASSERT_NOW(a_no_overlap, ctl.data_vld, !imm_rsp, "immediate response during a scan")

endmodule

FILE: rtl/core/subnet_interface_match_top.sv
// Top level of the subnet interface match block: entry RAM, scan sequencer, evaluator.
// Depends on sifm_pkg, sifm_ram, sifm_seq and sifm_eval.
`timescale 1ns / 1ps

// Subnet interface match. A request is taken at a rising edge with start high and
// busy low. Every request gives exactly one result, shown on rsp_data for one cycle
// with rsp_strobe high; the receiver cannot stall, so sample it when it appears.
// A write updates the table at the accepting edge; a write or the unused op code
// responds in the next cycle, with busy staying low, so these run one per cycle.
// A lookup or a check scans all 32 entries out of the entry RAM, one read per
// cycle; its read data passes the RAM's read register and then the result
// register, and busy stays high from acceptance until the result appears.
// The single read port of the entry RAM sets the scan length. Valid bits live in
// flip-flops and reset clears them at once; there is no clearing pass after reset.
module subnet_interface_match_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sifm_pkg::req_type req_data,
   output logic              rsp_strobe,
   output sifm_pkg::rsp_type rsp_data
);

   logic                          accept;
   logic                          scan_go;
   logic                          slot_ok;
   logic                          wr_iface_ok;
   logic                          ram_we;
   logic [sifm_pkg::ENTRY_AW-1:0] wr_idx;
   logic [sifm_pkg::ENTRY_AW-1:0] rd_addr;
   sifm_pkg::entry_type           wr_entry;
   sifm_pkg::entry_type           rd_entry;
   sifm_pkg::used_wr_type         used_wr;
   sifm_pkg::seq_ctl_type         ctl;
   sifm_pkg::op_type              op_ff;
   logic [31:0]                   ip_ff;
   logic [3:0]                    iface_ff;

   // Take a request only while no scan is in flight; this also keeps writes
   // away from the entries a scan is reading, so no forwarding is needed.
   assign accept  = start && !busy;
   assign scan_go = accept && ((req_data.op == sifm_pkg::OP_LOOKUP) ||
                               (req_data.op == sifm_pkg::OP_CHECK));

   // Drop writes to slots beyond the table or with an unknown interface.
   assign slot_ok     = 32'(req_data.slot) < 32'(sifm_pkg::NUM_ENTRIES);
   assign wr_iface_ok = 32'(req_data.iface_id) < 32'(sifm_pkg::NUM_IFACES);
   assign ram_we      = accept && (req_data.op == sifm_pkg::OP_WRITE) && slot_ok && wr_iface_ok;
   assign wr_idx      = sifm_pkg::ENTRY_AW'(req_data.slot);

   // Store all fields whatever slot_enable says; the valid bit gates matches.
   assign wr_entry.iface  = req_data.iface_id;
   assign wr_entry.mask   = req_data.mask_in;
   assign wr_entry.subnet = req_data.subnet_in;

   assign used_wr.en    = ram_we;
   assign used_wr.idx   = wr_idx;
   assign used_wr.value = req_data.slot_enable;

   // Hold the fields a scan needs for its whole length.
   always_ff @(posedge clock) begin
      if (scan_go) begin
         op_ff    <= req_data.op;
         ip_ff    <= req_data.ip_addr;
         iface_ff <= req_data.iface_id;
      end
   end

   sifm_ram #(
      .WIDTH ($bits(sifm_pkg::entry_type)),
      .DEPTH (sifm_pkg::NUM_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   sifm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start_scan (scan_go),
      .busy       (busy),
      .rd_addr    (rd_addr),
      .ctl        (ctl)
   );

   // Writes and the unused op code answer with an all-zero result next cycle.
   sifm_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .used_wr    (used_wr),
      .ctl        (ctl),
      .entry      (rd_entry),
      .scan_op    (op_ff),
      .ip_addr    (ip_ff),
      .iface_id   (iface_ff),
      .imm_rsp    (accept && !scan_go),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
